@@ rtl/core/fsr_pkg.sv @@
// ----------------------------------------------------------------------------
// fsr_pkg
// Shared constants and types for the serial frame receiver.
// ----------------------------------------------------------------------------
package fsr_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'hAF;
    localparam logic [7:0] FUNC_MAX   = 8'hF1;
    localparam logic [7:0] LEN_BAD    = 8'hFF;
    localparam logic [7:0] FUNC_POS   = 8'h01;
    localparam logic [7:0] POS_MIN_LEN = 8'd4;

    localparam int OFFSET_W = 10;
    localparam int GAIN_W   = 8;
    localparam int RAW_W    = 16;
    localparam int DIFF_W   = RAW_W + 1;
    localparam int POS_W    = 25;

    localparam logic [OFFSET_W-1:0] OFFSET_RST = 10'd350;
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 8'd20;

    localparam logic REG_OFFSET = 1'b0;
    localparam logic REG_GAIN   = 1'b1;

    typedef struct packed {
        logic             checksum_ok;
        logic [7:0]       func_code;
        logic [7:0]       payload_len;
        logic             pos_update;
        logic [RAW_W-1:0] x_raw;
        logic [RAW_W-1:0] y_raw;
    } frame_t;

    typedef struct packed {
        logic   valid;
        frame_t frame;
    } push_t;

endpackage

@@ rtl/core/fsr_front.sv @@
// ----------------------------------------------------------------------------
// fsr_front
// Byte parser: tracks header, function, length, payload and running sum.
// ----------------------------------------------------------------------------
module fsr_front
    import fsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output push_t      push,
    input  logic       push_ready
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_HDR2 = 3'd2;
    localparam logic [2:0] PH_FUNC = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_SUM  = 3'd5;

    logic [2:0]       phase_reg,  phase_next;
    logic [7:0]       left_reg,   left_next;
    logic [7:0]       count_reg,  count_next;
    logic [7:0]       sum_reg,    sum_next;
    logic [7:0]       func_reg,   func_next;
    logic [RAW_W-1:0] x_reg,      x_next;
    logic [RAW_W-1:0] y_reg,      y_next;
    logic             accept;
    logic             ok;

    assign in_ready = (phase_reg != PH_SUM) || push_ready;
    assign accept   = in_valid && in_ready;
    assign ok       = (rx_byte == sum_reg);

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        func_next  = func_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == HDR_FIRST)
                    begin
                        phase_next = PH_HDR1;
                        sum_next   = rx_byte;
                    end
                end
                PH_HDR1:
                begin
                    if (rx_byte == HDR_SECOND)
                    begin
                        phase_next = PH_HDR2;
                        sum_next   = sum_reg + rx_byte;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_HDR2:
                begin
                    if (rx_byte <= FUNC_MAX)
                    begin
                        phase_next = PH_FUNC;
                        func_next  = rx_byte;
                        sum_next   = sum_reg + rx_byte;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_FUNC:
                begin
                    if (rx_byte != LEN_BAD)
                    begin
                        phase_next = PH_DATA;
                        left_next  = rx_byte;
                        count_next = 8'd0;
                        sum_next   = sum_reg + rx_byte;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_DATA:
                begin
                    if (left_reg == 8'd0)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        case (count_reg)
                            8'd0:    x_next = {rx_byte, x_reg[7:0]};
                            8'd1:    x_next = {x_reg[15:8], rx_byte};
                            8'd2:    y_next = {rx_byte, y_reg[7:0]};
                            8'd3:    y_next = {y_reg[15:8], rx_byte};
                            default: ;
                        endcase
                        count_next = count_reg + 8'd1;
                        left_next  = left_reg - 8'd1;
                        sum_next   = sum_reg + rx_byte;
                        if (left_reg == 8'd1)
                        begin
                            phase_next = PH_SUM;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        push.valid             = accept && (phase_reg == PH_SUM);
        push.frame.checksum_ok = ok;
        push.frame.func_code   = func_reg;
        push.frame.payload_len = count_reg;
        push.frame.pos_update  = ok && (func_reg == FUNC_POS) && (count_reg >= POS_MIN_LEN);
        push.frame.x_raw       = x_reg;
        push.frame.y_raw       = y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            left_reg  <= 8'd0;
            count_reg <= 8'd0;
            sum_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
    end

endmodule

@@ rtl/core/fsr_queue.sv @@
// ----------------------------------------------------------------------------
// fsr_queue
// Two-entry frame queue between parser and position scaler.
// ----------------------------------------------------------------------------
module fsr_queue
    import fsr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  push_t  push,
    output logic   push_ready,
    output logic   pop_valid,
    input  logic   pop_ready,
    output frame_t pop_frame
);

    frame_t     mem_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_frame  = mem_reg[rd_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_next  = do_push ? ~wr_reg : wr_reg;
        rd_next  = do_pop  ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push.frame;
        end
    end

endmodule

@@ rtl/core/fsr_back.sv @@
// ----------------------------------------------------------------------------
// fsr_back
// Position scaler: offset subtract stage, then multiply into output register.
// ----------------------------------------------------------------------------
module fsr_back
    import fsr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  frame_t                  pop_frame,
    input  logic [OFFSET_W-1:0]     position_offset,
    input  logic [GAIN_W-1:0]       position_gain,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    checksum_ok,
    output logic [7:0]              func_code,
    output logic [7:0]              payload_len,
    output logic                    pos_update,
    output logic signed [POS_W-1:0] x_pos,
    output logic signed [POS_W-1:0] y_pos
);

    logic                            s1_valid_reg;
    logic                            s1_ok_reg;
    logic [7:0]                      s1_func_reg;
    logic [7:0]                      s1_len_reg;
    logic                            s1_upd_reg;
    logic signed [DIFF_W-1:0]        s1_xd_reg, s1_xd_next;
    logic signed [DIFF_W-1:0]        s1_yd_reg, s1_yd_next;
    logic                            o_valid_reg;
    logic                            o_ok_reg;
    logic [7:0]                      o_func_reg;
    logic [7:0]                      o_len_reg;
    logic                            o_upd_reg;
    logic signed [POS_W-1:0]         o_x_reg, o_x_next;
    logic signed [POS_W-1:0]         o_y_reg, o_y_next;
    logic signed [DIFF_W+GAIN_W:0]   x_prod;
    logic signed [DIFF_W+GAIN_W:0]   y_prod;
    logic signed [DIFF_W-1:0]        offset_s;
    logic signed [GAIN_W:0]          gain_s;
    logic                            o_adv;
    logic                            s1_adv;

    assign o_adv     = !o_valid_reg || out_ready;
    assign s1_adv    = !s1_valid_reg || o_adv;
    assign pop_ready = s1_adv;

    assign offset_s = signed'({{(DIFF_W-OFFSET_W){1'b0}}, position_offset});
    assign gain_s   = signed'({1'b0, position_gain});

    always_comb
    begin
        s1_xd_next = signed'({pop_frame.x_raw[RAW_W-1], pop_frame.x_raw}) - offset_s;
        s1_yd_next = signed'({pop_frame.y_raw[RAW_W-1], pop_frame.y_raw}) - offset_s;
        x_prod     = s1_xd_reg * gain_s;
        y_prod     = s1_yd_reg * gain_s;
        o_x_next   = s1_upd_reg ? x_prod[POS_W-1:0] : '0;
        o_y_next   = s1_upd_reg ? y_prod[POS_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= pop_valid;
            end
            if (o_adv)
            begin
                o_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && pop_valid)
        begin
            s1_ok_reg   <= pop_frame.checksum_ok;
            s1_func_reg <= pop_frame.func_code;
            s1_len_reg  <= pop_frame.payload_len;
            s1_upd_reg  <= pop_frame.pos_update;
            s1_xd_reg   <= s1_xd_next;
            s1_yd_reg   <= s1_yd_next;
        end
        if (o_adv && s1_valid_reg)
        begin
            o_ok_reg   <= s1_ok_reg;
            o_func_reg <= s1_func_reg;
            o_len_reg  <= s1_len_reg;
            o_upd_reg  <= s1_upd_reg;
            o_x_reg    <= o_x_next;
            o_y_reg    <= o_y_next;
        end
    end

    assign out_valid   = o_valid_reg;
    assign checksum_ok = o_ok_reg;
    assign func_code   = o_func_reg;
    assign payload_len = o_len_reg;
    assign pos_update  = o_upd_reg;
    assign x_pos       = o_x_reg;
    assign y_pos       = o_y_reg;

endmodule

@@ rtl/core/serial_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// serial_frame_receiver_unit
// Framed serial command parser with checksum check and position scaling.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------
//  input   | in_valid / in_ready        | rx_byte
//  output  | out_valid / out_ready      | checksum_ok func_code payload_len
//          |                            | pos_update x_pos y_pos
//  config  | psel penable pwrite pready | paddr pwdata prdata
//
//  One byte per cycle is accepted while in_ready is high. After its sum
//  byte, a frame result passes the queue, offset stage and multiply stage
//  into the output register. Reset clears the parser to idle, empties the
//  queue and loads offset 350 and gain 20. in_ready drops only on a sum byte
//  while the two-entry queue is full; header and payload bytes never stall.
// ----------------------------------------------------------------------------
module serial_frame_receiver_unit
    import fsr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              rx_byte,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    checksum_ok,
    output logic [7:0]              func_code,
    output logic [7:0]              payload_len,
    output logic                    pos_update,
    output logic signed [POS_W-1:0] x_pos,
    output logic signed [POS_W-1:0] y_pos,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [OFFSET_W-1:0] offset_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic                wr_en;
    push_t               push;
    logic                push_ready;
    logic                pop_valid;
    logic                pop_ready;
    frame_t              pop_frame;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RST;
            gain_reg   <= GAIN_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_OFFSET)
            begin
                offset_reg <= pwdata[OFFSET_W-1:0];
            end
            else
            begin
                gain_reg <= pwdata[GAIN_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_GAIN) ? {{(32-GAIN_W){1'b0}}, gain_reg}
                                           : {{(32-OFFSET_W){1'b0}}, offset_reg};

    fsr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .push       (push),
        .push_ready (push_ready)
    );

    fsr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_frame  (pop_frame)
    );

    fsr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_frame       (pop_frame),
        .position_offset (offset_reg),
        .position_gain   (gain_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .checksum_ok     (checksum_ok),
        .func_code       (func_code),
        .payload_len     (payload_len),
        .pos_update      (pos_update),
        .x_pos           (x_pos),
        .y_pos           (y_pos)
    );

endmodule

@@ rtl/core/fsr_checker.sv @@
// ----------------------------------------------------------------------------
// fsr_checker
// Port-level checks on frame results of the serial frame receiver.
// ----------------------------------------------------------------------------
module fsr_checker
    import fsr_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic                    checksum_ok,
    input logic [7:0]              func_code,
    input logic [7:0]              payload_len,
    input logic                    pos_update,
    input logic signed [POS_W-1:0] x_pos,
    input logic signed [POS_W-1:0] y_pos
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(func_code)
            && $stable(payload_len) && $stable(x_pos) && $stable(y_pos))
        else $error("result changed while stalled");

    a_upd_cond: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pos_update |-> checksum_ok && func_code == FUNC_POS
            && payload_len >= POS_MIN_LEN)
        else $error("position update without valid frame");

    a_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pos_update |-> x_pos == '0 && y_pos == '0)
        else $error("position nonzero without update");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> payload_len != 8'd0 && payload_len != LEN_BAD
            && func_code <= FUNC_MAX)
        else $error("result with impossible length or function");

endmodule

bind serial_frame_receiver_unit fsr_checker u_fsr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .checksum_ok (checksum_ok),
    .func_code   (func_code),
    .payload_len (payload_len),
    .pos_update  (pos_update),
    .x_pos       (x_pos),
    .y_pos       (y_pos)
);

@@ sim/serial_frame_receiver_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_unit_test
// Self-checking testbench for the serial frame receiver. A directed table
// covers broken headers, a length of 0xFF, a zero length, a failed checksum
// and a position frame at word extremes. After it, random frames, noise and
// cut-off frames run under several offset and gain settings. A local frame
// parser predicts the reports that the table does not give, and the block's
// output is compared with them under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module serial_frame_receiver_unit_test;
    import fsr_pkg::*;

    localparam int PHASE_BYTES  = 250;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SYNC1,
        PH_SYNC2,
        PH_FUNC,
        PH_BODY,
        PH_CSUM
    } parse_phase_t;

    typedef struct packed {
        logic                    checksum_ok;
        logic [7:0]              func_code;
        logic [7:0]              payload_len;
        logic                    pos_update;
        logic signed [POS_W-1:0] x_pos;
        logic signed [POS_W-1:0] y_pos;
    } report_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        report_t    rep;
    } table_row_t;

    localparam report_t NO_REPORT = '0;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [7:0]              rx_byte;
    logic                    out_valid;
    logic                    out_ready;
    logic                    checksum_ok;
    logic [7:0]              func_code;
    logic [7:0]              payload_len;
    logic                    pos_update;
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [2:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    parse_phase_t    phase;
    logic [7:0]      left_cnt;
    logic [7:0]      body_cnt;
    logic [7:0]      sum_acc;
    logic [7:0]      frame_fn;
    logic [15:0]     x_word;
    logic [15:0]     y_word;
    logic [9:0]      cfg_offset;
    logic [7:0]      cfg_gain;

    report_t         pending_reports[$];
    table_row_t      directed_rows[$];
    report_t         want;
    report_t         got;

    int              faults;
    int              bytes_sent;
    int              reports_seen;
    int              pos_seen;
    int              bad_sum_seen;
    int              settings_used;
    int              calm_bytes;
    int              cycle_count;
    logic            ready_next;
    int              ready_hold;

    serial_frame_receiver_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .checksum_ok (checksum_ok),
        .func_code   (func_code),
        .payload_len (payload_len),
        .pos_update  (pos_update),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, pending_reports.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic signed [POS_W-1:0] scale_word(input logic [15:0] raw);
        int w;
        int v;
        w = int'($signed(raw));
        v = (w - int'(cfg_offset)) * int'(cfg_gain);
        return v[POS_W-1:0];
    endfunction

    function automatic void parse_byte(input logic [7:0] b, output bit made,
                                       output report_t rep);
        made = 1'b0;
        rep  = NO_REPORT;
        case (phase)
            PH_IDLE:
            begin
                if (b == HDR_FIRST)
                begin
                    phase   = PH_SYNC1;
                    sum_acc = b;
                end
            end
            PH_SYNC1:
            begin
                if (b == HDR_SECOND)
                begin
                    phase   = PH_SYNC2;
                    sum_acc = sum_acc + b;
                end
                else
                    phase = PH_IDLE;
            end
            PH_SYNC2:
            begin
                if (b <= FUNC_MAX)
                begin
                    phase    = PH_FUNC;
                    frame_fn = b;
                    sum_acc  = sum_acc + b;
                end
                else
                    phase = PH_IDLE;
            end
            PH_FUNC:
            begin
                if (b != LEN_BAD)
                begin
                    phase    = PH_BODY;
                    left_cnt = b;
                    body_cnt = 8'd0;
                    sum_acc  = sum_acc + b;
                end
                else
                    phase = PH_IDLE;
            end
            PH_BODY:
            begin
                if (left_cnt == 8'd0)
                    phase = PH_IDLE;
                else
                begin
                    case (body_cnt)
                        8'd0:    x_word[15:8] = b;
                        8'd1:    x_word[7:0]  = b;
                        8'd2:    y_word[15:8] = b;
                        8'd3:    y_word[7:0]  = b;
                        default: ;
                    endcase
                    body_cnt = body_cnt + 8'd1;
                    left_cnt = left_cnt - 8'd1;
                    sum_acc  = sum_acc + b;
                    if (left_cnt == 8'd0)
                        phase = PH_CSUM;
                end
            end
            PH_CSUM:
            begin
                phase           = PH_IDLE;
                made            = 1'b1;
                rep.checksum_ok = (b == sum_acc);
                rep.func_code   = frame_fn;
                rep.payload_len = body_cnt;
                rep.pos_update  = rep.checksum_ok && frame_fn == FUNC_POS &&
                                  body_cnt >= POS_MIN_LEN;
                if (rep.pos_update)
                begin
                    rep.x_pos = scale_word(x_word);
                    rep.y_pos = scale_word(y_word);
                end
            end
            default: phase = PH_IDLE;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm_bytes > 0)
        begin
            calm_bytes--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_bytes = $urandom_range(20, 80);
            return 0;
        end
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic typed,
                                    input report_t rep);
        table_row_t row;
        row.rx    = b;
        row.typed = typed;
        row.rep   = rep;
        directed_rows.push_back(row);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic typed,
                             input report_t typed_rep);
        int      gap;
        bit      made;
        report_t pred;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        parse_byte(b, made, pred);
        if (made)
            pending_reports.push_back(typed ? typed_rep : pred);
    endtask

    task automatic send_random_frame();
        logic [7:0] fq[$];
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] fn;
        logic [7:0] ln;
        int         r;
        int         cut;
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4)) fq.push_back(8'($urandom));
        fq.push_back(HDR_FIRST);
        sum = HDR_FIRST;
        b = ($urandom_range(0, 29) == 0) ? 8'($urandom) : HDR_SECOND;
        fq.push_back(b);
        sum = sum + b;
        r = $urandom_range(0, 99);
        if (r < 55)
            fn = FUNC_POS;
        else if (r < 63)
            fn = 8'h00;
        else if (r < 71)
            fn = FUNC_MAX;
        else if (r < 95)
            fn = 8'($urandom_range(0, 241));
        else
            fn = 8'($urandom_range(242, 255));
        fq.push_back(fn);
        sum = sum + fn;
        r = $urandom_range(0, 99);
        if (r < 2)
            ln = LEN_BAD;
        else if (r < 8)
            ln = 8'd0;
        else if (r < 70)
            ln = 8'($urandom_range(1, 8));
        else if (r < 96)
            ln = 8'($urandom_range(9, 40));
        else if (r < 99)
            ln = 8'($urandom_range(41, 120));
        else
            ln = 8'd254;
        fq.push_back(ln);
        sum = sum + ln;
        if (ln != LEN_BAD)
        begin
            for (int i = 0; i < int'(ln); i++)
            begin
                r = $urandom_range(0, 9);
                b = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : (r == 2) ? 8'h80 :
                    (r == 3) ? 8'h7F : 8'($urandom);
                fq.push_back(b);
                sum = sum + b;
            end
            fq.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom) : sum);
        end
        if ($urandom_range(0, 15) == 0)
        begin
            cut = $urandom_range(1, fq.size() - 1);
            while (fq.size() > cut)
                void'(fq.pop_back());
        end
        foreach (fq[i])
            push_byte(fq[i], 1'b0, NO_REPORT);
    endtask

    task automatic apb_cycle(input logic wr, input logic [2:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic retune(input logic [9:0] off, input logic [7:0] gn);
        logic [31:0] wdata;
        logic [31:0] rdata;
        logic [31:0] exp_rd;
        logic        idx;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (int i = 0; i < 2; i++)
        begin
            idx   = (i == 0) ? REG_OFFSET : REG_GAIN;
            wdata = $urandom;
            if (idx == REG_OFFSET)
                wdata[OFFSET_W-1:0] = off;
            else
                wdata[GAIN_W-1:0] = gn;
            apb_cycle(1'b1, {idx, 2'b00}, wdata, rdata);
        end
        cfg_offset = off;
        cfg_gain   = gn;
        for (int i = 0; i < 2; i++)
        begin
            idx    = (i == 0) ? REG_OFFSET : REG_GAIN;
            exp_rd = (idx == REG_OFFSET) ? {22'd0, cfg_offset} : {24'd0, cfg_gain};
            apb_cycle(1'b0, {idx, 2'b00}, 32'd0, rdata);
            if (rdata !== exp_rd)
            begin
                if (faults < 10)
                    $display("%0t register %0d readback: expected %08h, got %08h",
                             $time, i, exp_rd, rdata);
                faults++;
            end
        end
        settings_used++;
    endtask

    initial
    begin
        out_ready  <= 1'b0;
        ready_next  = 1'b0;
        ready_hold  = 0;
        forever
        begin
            @(negedge clk);
            if (ready_hold == 0)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8:
                    begin
                        ready_next = 1'b0;
                        ready_hold = $urandom_range(0, 2);
                    end
                    9:
                    begin
                        ready_next = 1'b0;
                        ready_hold = $urandom_range(10, 40);
                    end
                    10:
                    begin
                        ready_next = 1'b1;
                        ready_hold = $urandom_range(60, 150);
                    end
                    default:
                    begin
                        ready_next = 1'b1;
                        ready_hold = $urandom_range(0, 6);
                    end
                endcase
            end
            else
                ready_hold--;
            out_ready <= ready_next;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got.checksum_ok = checksum_ok;
            got.func_code   = func_code;
            got.payload_len = payload_len;
            got.pos_update  = pos_update;
            got.x_pos       = x_pos;
            got.y_pos       = y_pos;
            reports_seen++;
            if (got.pos_update)
                pos_seen++;
            if (!got.checksum_ok)
                bad_sum_seen++;
            if (pending_reports.size() == 0)
            begin
                if (faults < 10)
                    $display("%0t unexpected report: ok=%0b func=%02h len=%0d upd=%0b x=%0d y=%0d",
                             $time, got.checksum_ok, got.func_code, got.payload_len,
                             got.pos_update, got.x_pos, got.y_pos);
                faults++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got !== want)
                begin
                    if (faults < 10)
                    begin
                        $display("%0t expected: ok=%0b func=%02h len=%0d upd=%0b x=%0d y=%0d",
                                 $time, want.checksum_ok, want.func_code, want.payload_len,
                                 want.pos_update, want.x_pos, want.y_pos);
                        $display("%0t actual:   ok=%0b func=%02h len=%0d upd=%0b x=%0d y=%0d",
                                 $time, got.checksum_ok, got.func_code, got.payload_len,
                                 got.pos_update, got.x_pos, got.y_pos);
                    end
                    faults++;
                end
            end
        end
    end

    initial
    begin
        int          mark;
        logic [9:0]  off;
        logic [7:0]  gn;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = 8'd0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'd0;
        phase         = PH_IDLE;
        left_cnt      = 8'd0;
        body_cnt      = 8'd0;
        sum_acc       = 8'd0;
        frame_fn      = 8'd0;
        x_word        = 16'd0;
        y_word        = 16'd0;
        cfg_offset    = OFFSET_RST;
        cfg_gain      = GAIN_RST;
        faults        = 0;
        bytes_sent    = 0;
        reports_seen  = 0;
        pos_seen      = 0;
        bad_sum_seen  = 0;
        settings_used = 1;
        calm_bytes    = 0;
        cycle_count   = 0;

        // function above the limit
        add_row(HDR_FIRST,  1'b0, NO_REPORT);
        add_row(HDR_SECOND, 1'b0, NO_REPORT);
        add_row(8'hF2,      1'b0, NO_REPORT);
        // repeated first header byte is dropped, not re-synced
        add_row(HDR_FIRST,  1'b0, NO_REPORT);
        add_row(HDR_FIRST,  1'b0, NO_REPORT);
        // length 0xFF
        add_row(HDR_FIRST,  1'b0, NO_REPORT);
        add_row(HDR_SECOND, 1'b0, NO_REPORT);
        add_row(FUNC_MAX,   1'b0, NO_REPORT);
        add_row(LEN_BAD,    1'b0, NO_REPORT);
        // zero length swallows the next byte
        add_row(HDR_FIRST,  1'b0, NO_REPORT);
        add_row(HDR_SECOND, 1'b0, NO_REPORT);
        add_row(8'h00,      1'b0, NO_REPORT);
        add_row(8'h00,      1'b0, NO_REPORT);
        add_row(HDR_FIRST,  1'b0, NO_REPORT);
        // one-byte frame with a bad checksum
        add_row(HDR_FIRST,  1'b0, NO_REPORT);
        add_row(HDR_SECOND, 1'b0, NO_REPORT);
        add_row(FUNC_MAX,   1'b0, NO_REPORT);
        add_row(8'h01,      1'b0, NO_REPORT);
        add_row(8'h00,      1'b0, NO_REPORT);
        add_row(8'hFF,      1'b1,
                report_t'{1'b0, 8'hF1, 8'd1, 1'b0, 25'sd0, 25'sd0});
        // position frame at the word extremes, reset offset and gain
        add_row(HDR_FIRST,  1'b0, NO_REPORT);
        add_row(HDR_SECOND, 1'b0, NO_REPORT);
        add_row(FUNC_POS,   1'b0, NO_REPORT);
        add_row(8'h04,      1'b0, NO_REPORT);
        add_row(8'h80,      1'b0, NO_REPORT);
        add_row(8'h00,      1'b0, NO_REPORT);
        add_row(8'h7F,      1'b0, NO_REPORT);
        add_row(8'hFF,      1'b0, NO_REPORT);
        add_row(8'h5C,      1'b1,
                report_t'{1'b1, 8'h01, 8'd4, 1'b1, -25'sd662360, 25'sd648340});

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            push_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].rep);

        for (int s = 0; s < 7; s++)
        begin
            case (s)
                0:       begin off = OFFSET_RST; gn = GAIN_RST; end
                1:       begin off = 10'd1023;   gn = 8'd255;   end
                2:       begin off = 10'd0;      gn = 8'd0;     end
                3:       begin off = 10'd0;      gn = 8'd255;   end
                4:       begin off = 10'd1023;   gn = 8'd1;     end
                default: begin off = 10'($urandom); gn = 8'($urandom); end
            endcase
            if (s != 0)
                retune(off, gn);
            mark = bytes_sent;
            while (bytes_sent - mark < PHASE_BYTES)
                send_random_frame();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d bytes sent, %0d frame reports checked under %0d offset/gain settings",
                 bytes_sent, reports_seen, settings_used);
        $display("%0d reports with position update, %0d with bad checksum, %0d faults",
                 pos_seen, bad_sum_seen, faults);
        if (faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
